>>> sv/toba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// toba_pkg: shared types and constants of the trade OHLC bar aggregator
// Field widths, bucket divider reciprocals, the opening gate time and the
// structs that carry a trade, a bar and a result between the modules.
// ----------------------------------------------------------------------------
package toba_pkg;

  localparam int unsigned INST_W     = 4;
  localparam int unsigned PRICE_W    = 31;
  localparam int unsigned QTY_W      = 48;
  localparam int unsigned AMT_W      = 63;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned TIME_W     = 28;
  localparam int unsigned DAY_W      = 27;
  localparam int unsigned SLOT_OUT_W = 8;
  localparam int unsigned CUR_W      = 32;

  localparam int unsigned INSTRUMENTS = 16;
  localparam int unsigned IDX_W       = $clog2(INSTRUMENTS);

  localparam int unsigned ONE_MIN_RING_DEF  = 256;
  localparam int unsigned FIVE_MIN_RING_DEF = 64;

  // Bucket number of a time is floor(t * REC >> SH). The reciprocals are
  // rounded up and exact for every 28-bit time.
  localparam int unsigned REC_W  = 29;
  localparam int unsigned PROD_W = TIME_W + REC_W;
  localparam int unsigned Q_W    = 12;
  localparam logic [REC_W-1:0] REC_ONE_MIN  = 29'd351843721;  // 2^45 / 100000
  localparam int unsigned      SH_ONE_MIN   = 45;
  localparam logic [REC_W-1:0] REC_FIVE_MIN = 29'd281474977;  // 2^47 / 500000
  localparam int unsigned      SH_FIVE_MIN  = 47;

  localparam logic [TIME_W-1:0] GATE_TIME = 28'd93000000;

  localparam logic TF_ONE_MIN  = 1'b0;
  localparam logic TF_FIVE_MIN = 1'b1;

  typedef struct packed {
    logic [INST_W-1:0]  instrument;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [AMT_W-1:0]   amount;
    logic [TIME_W-1:0]  trade_time;
    logic [TIME_W-1:0]  feed_time;
    logic [Q_W-1:0]     bkt_one;
    logic [Q_W-1:0]     bkt_five;
  } trade_t;

  typedef struct packed {
    logic [PRICE_W-1:0] open_price;
    logic [PRICE_W-1:0] high_price;
    logic [PRICE_W-1:0] low_price;
    logic [PRICE_W-1:0] close_price;
    logic [QTY_W-1:0]   volume;
    logic [AMT_W-1:0]   amount;
    logic [CNT_W-1:0]   trade_count;
    logic [TIME_W-1:0]  bar_time;
  } bar_t;

  typedef struct packed {
    logic                  timeframe;
    logic [SLOT_OUT_W-1:0] slot;
    bar_t                  bar;
    logic                  last;
  } result_t;

endpackage
`default_nettype wire

>>> sv/toba_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// toba_if: trade input channel and bar result channel
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface toba_in_if;
  logic                          valid;
  logic                          ready;
  logic [toba_pkg::INST_W-1:0]   instrument;
  logic [toba_pkg::PRICE_W-1:0]  trade_price;
  logic [toba_pkg::QTY_W-1:0]    trade_qty;
  logic [toba_pkg::AMT_W-1:0]    trade_amount;
  logic [toba_pkg::TIME_W-1:0]   trade_time;
  logic [toba_pkg::TIME_W-1:0]   feed_time;

  modport source (output valid, instrument, trade_price, trade_qty, trade_amount,
                  trade_time, feed_time, input ready);
  modport sink (input valid, instrument, trade_price, trade_qty, trade_amount,
                trade_time, feed_time, output ready);
endinterface

interface toba_out_if;
  logic                            valid;
  logic                            ready;
  logic                            timeframe;
  logic [toba_pkg::SLOT_OUT_W-1:0] slot;
  logic [toba_pkg::PRICE_W-1:0]    open_price;
  logic [toba_pkg::PRICE_W-1:0]    high_price;
  logic [toba_pkg::PRICE_W-1:0]    low_price;
  logic [toba_pkg::PRICE_W-1:0]    close_price;
  logic [toba_pkg::QTY_W-1:0]      volume;
  logic [toba_pkg::AMT_W-1:0]      amount;
  logic [toba_pkg::CNT_W-1:0]      trade_count;
  logic [toba_pkg::TIME_W-1:0]     bar_time;
  logic                            last;

  modport source (output valid, timeframe, slot, open_price, high_price, low_price,
                  close_price, volume, amount, trade_count, bar_time, last,
                  input ready);
  modport sink (input valid, timeframe, slot, open_price, high_price, low_price,
                close_price, volume, amount, trade_count, bar_time, last,
                output ready);
endinterface
`default_nettype wire

>>> sv/trade_ohlc_bar_aggregator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trade_ohlc_bar_aggregator: per-instrument one- and five-minute OHLC bars
// A trade on in_ch that touches its one-minute bar updates or opens
// the touched bars and emits them on out_ch, one-minute first, last marked.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one trade per transaction. The trade is registered together
//   with its one- and five-minute bucket numbers, which come from reciprocal
//   multipliers at the input. Once the result register can take them, the
//   bar units the trade touches update their state and load the results
//   into a two-entry result register.
//   Throughput: one trade per cycle while out_ch is ready and each trade yields
//   at most one result; after a trade that yields two, the next trade waits
//   until the first is taken, as the single result channel sets the limit.
//   When out_ch stalls, the result register holds its entries and one more
//   trade waits in the input register; in_ch.ready drops after that.
//   cfg_we writes trading_day; write it only while the block is idle.
//   Reset (rst_n low, synchronous) clears all bars, cursors and handshakes.
// ----------------------------------------------------------------------------
module trade_ohlc_bar_aggregator #(
  parameter int unsigned ONE_MIN_RING  = toba_pkg::ONE_MIN_RING_DEF,
  parameter int unsigned FIVE_MIN_RING = toba_pkg::FIVE_MIN_RING_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  toba_in_if.sink                     in_ch,
  toba_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [toba_pkg::DAY_W-1:0]  cfg_wdata
);

  logic [toba_pkg::DAY_W-1:0]  trading_day_r;
  logic                        in_v_r;
  toba_pkg::trade_t            trade_r;
  toba_pkg::trade_t            trade_nxt;
  logic [toba_pkg::PROD_W-1:0] prod_one, prod_five;
  logic                        in_take;
  logic                        adv;
  logic                        can_take;
  logic [toba_pkg::IDX_W-1:0]  idx;
  logic                        inst_ok;
  logic                        gate_ok;
  logic                        touch_one, touch_five;
  logic                        commit_one, commit_five;
  logic [toba_pkg::SLOT_OUT_W-1:0] slot_one, slot_five;
  toba_pkg::bar_t              bar_one, bar_five;
  toba_pkg::result_t           res0, res1;
  logic [1:0]                  push_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trading_day_r <= '0;
    end else if (cfg_we) begin
      trading_day_r <= cfg_wdata;
    end
  end

  // Bucket numbers of the trade time, computed on the way into the register.
  assign prod_one  = toba_pkg::PROD_W'(in_ch.trade_time) *
                     toba_pkg::PROD_W'(toba_pkg::REC_ONE_MIN);
  assign prod_five = toba_pkg::PROD_W'(in_ch.trade_time) *
                     toba_pkg::PROD_W'(toba_pkg::REC_FIVE_MIN);

  always_comb begin
    trade_nxt.instrument = in_ch.instrument;
    trade_nxt.price      = in_ch.trade_price;
    trade_nxt.qty        = in_ch.trade_qty;
    trade_nxt.amount     = in_ch.trade_amount;
    trade_nxt.trade_time = in_ch.trade_time;
    trade_nxt.feed_time  = in_ch.feed_time;
    trade_nxt.bkt_one    = toba_pkg::Q_W'(prod_one >> toba_pkg::SH_ONE_MIN);
    trade_nxt.bkt_five   = toba_pkg::Q_W'(prod_five >> toba_pkg::SH_FIVE_MIN);
  end

  assign adv         = in_v_r & can_take;
  assign in_ch.ready = ~in_v_r | can_take;
  assign in_take     = in_ch.valid & in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      trade_r <= trade_nxt;
    end
  end

  assign idx     = toba_pkg::IDX_W'(trade_r.instrument);
  assign inst_ok = (32'(trade_r.instrument) < toba_pkg::INSTRUMENTS);
  assign gate_ok = (trade_r.feed_time >= toba_pkg::GATE_TIME);

  // The five-minute bar is left alone when the one-minute bar cannot move.
  assign commit_one  = adv & inst_ok & touch_one;
  assign commit_five = commit_one & touch_five;

  toba_bar_unit #(.RING(ONE_MIN_RING)) u_one_min (
    .clk     (clk),
    .rst_n   (rst_n),
    .commit  (commit_one),
    .idx     (idx),
    .trade   (trade_r),
    .bucket  (trade_r.bkt_one),
    .gate_ok (gate_ok),
    .touched (touch_one),
    .slot_o  (slot_one),
    .bar_o   (bar_one)
  );

  toba_bar_unit #(.RING(FIVE_MIN_RING)) u_five_min (
    .clk     (clk),
    .rst_n   (rst_n),
    .commit  (commit_five),
    .idx     (idx),
    .trade   (trade_r),
    .bucket  (trade_r.bkt_five),
    .gate_ok (gate_ok),
    .touched (touch_five),
    .slot_o  (slot_five),
    .bar_o   (bar_five)
  );

  always_comb begin
    res0.timeframe = toba_pkg::TF_ONE_MIN;
    res0.slot      = slot_one;
    res0.bar       = bar_one;
    res0.last      = ~touch_five;
    res1.timeframe = toba_pkg::TF_FIVE_MIN;
    res1.slot      = slot_five;
    res1.bar       = bar_five;
    res1.last      = 1'b1;
    if (!inst_ok || !touch_one) begin
      push_cnt = 2'd0;
    end else if (!touch_five) begin
      push_cnt = 2'd1;
    end else begin
      push_cnt = 2'd2;
    end
  end

  toba_res_buf u_res_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (adv),
    .push_cnt (push_cnt),
    .res0     (res0),
    .res1     (res1),
    .can_take (can_take),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

>>> sv/toba_bar_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// toba_bar_unit: current bar of one timeframe for every instrument
// Holds cursor, ring slot, bucket number and bar per instrument, and works out
// the updated or newly opened bar for the trade in the compute stage.
// ----------------------------------------------------------------------------
module toba_bar_unit #(
  parameter int unsigned RING = toba_pkg::ONE_MIN_RING_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             commit,
  input  logic [toba_pkg::IDX_W-1:0]       idx,
  input  toba_pkg::trade_t                 trade,
  input  logic [toba_pkg::Q_W-1:0]         bucket,
  input  logic                             gate_ok,
  output logic                             touched,
  output logic [toba_pkg::SLOT_OUT_W-1:0]  slot_o,
  output toba_pkg::bar_t                   bar_o
);

  localparam int unsigned SLOT_W = $clog2(RING);

  logic [toba_pkg::CUR_W-1:0] cur_r  [toba_pkg::INSTRUMENTS];
  logic [SLOT_W-1:0]          slot_r [toba_pkg::INSTRUMENTS];
  logic [toba_pkg::Q_W-1:0]   bkt_r  [toba_pkg::INSTRUMENTS];
  toba_pkg::bar_t             bar_r  [toba_pkg::INSTRUMENTS];

  logic [toba_pkg::CUR_W-1:0] cur, cur_nxt;
  logic [SLOT_W-1:0]          slot, slot_nxt;
  toba_pkg::bar_t             bar, bar_nxt;
  logic                       hit;
  logic [toba_pkg::QTY_W:0]   vol_sum;
  logic [toba_pkg::AMT_W:0]   amt_sum;

  assign cur  = cur_r[idx];
  assign slot = slot_r[idx];
  assign bar  = bar_r[idx];
  assign hit  = (bucket == bkt_r[idx]);

  assign vol_sum = {1'b0, bar.volume} + {1'b0, trade.qty};
  assign amt_sum = {1'b0, bar.amount} + {1'b0, trade.amount};

  always_comb begin
    cur_nxt  = cur;
    slot_nxt = slot;
    bar_nxt  = bar;
    if (hit) begin
      bar_nxt.close_price = trade.price;
      bar_nxt.bar_time    = trade.trade_time;
      if (bar.low_price > trade.price) begin
        bar_nxt.low_price = trade.price;
      end
      if (bar.high_price < trade.price) begin
        bar_nxt.high_price = trade.price;
      end
      bar_nxt.volume = vol_sum[toba_pkg::QTY_W] ? '1 : vol_sum[toba_pkg::QTY_W-1:0];
      bar_nxt.amount = amt_sum[toba_pkg::AMT_W] ? '1 : amt_sum[toba_pkg::AMT_W-1:0];
      if (bar.trade_count != '1) begin
        bar_nxt.trade_count = bar.trade_count + 1'b1;
      end
    end else begin
      cur_nxt = cur + 1'b1;
      // Cursors zero and one both map to slot zero, and so does the wrap.
      if (cur == '0 || cur_nxt == '0 || slot == SLOT_W'(RING - 1)) begin
        slot_nxt = '0;
      end else begin
        slot_nxt = slot + 1'b1;
      end
      bar_nxt.open_price  = trade.price;
      bar_nxt.high_price  = trade.price;
      bar_nxt.low_price   = trade.price;
      bar_nxt.close_price = trade.price;
      bar_nxt.volume      = trade.qty;
      bar_nxt.amount      = trade.amount;
      bar_nxt.trade_count = toba_pkg::CNT_W'(1);
      bar_nxt.bar_time    = trade.trade_time;
    end
  end

  assign touched = hit | gate_ok;
  assign slot_o  = toba_pkg::SLOT_OUT_W'(slot_nxt);
  assign bar_o   = bar_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < toba_pkg::INSTRUMENTS; i++) begin
        cur_r[i]  <= '0;
        slot_r[i] <= '0;
        bkt_r[i]  <= '0;
        bar_r[i]  <= '0;
      end
    end else if (commit) begin
      cur_r[idx]  <= cur_nxt;
      slot_r[idx] <= slot_nxt;
      bkt_r[idx]  <= bucket;
      bar_r[idx]  <= bar_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/toba_res_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// toba_res_buf: two-entry result register
// Takes the results of a trade, up to two, at once and hands them to the
// result channel one transaction per cycle while out_ch is ready.
// ----------------------------------------------------------------------------
module toba_res_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [1:0]           push_cnt,
  input  toba_pkg::result_t    res0,
  input  toba_pkg::result_t    res1,
  output logic                 can_take,
  toba_out_if.source           out_ch
);

  toba_pkg::result_t ent_r [2];
  logic [1:0]        cnt_r;
  logic              pop;

  assign pop      = out_ch.valid & out_ch.ready;
  assign can_take = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (push) begin
      cnt_r <= push_cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // A push only happens when the register is empty or drains in this cycle.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[0] <= res0;
      ent_r[1] <= res1;
    end else if (pop) begin
      ent_r[0] <= ent_r[1];
    end
  end

  assign out_ch.valid       = (cnt_r != 2'd0);
  assign out_ch.timeframe   = ent_r[0].timeframe;
  assign out_ch.slot        = ent_r[0].slot;
  assign out_ch.open_price  = ent_r[0].bar.open_price;
  assign out_ch.high_price  = ent_r[0].bar.high_price;
  assign out_ch.low_price   = ent_r[0].bar.low_price;
  assign out_ch.close_price = ent_r[0].bar.close_price;
  assign out_ch.volume      = ent_r[0].bar.volume;
  assign out_ch.amount      = ent_r[0].bar.amount;
  assign out_ch.trade_count = ent_r[0].bar.trade_count;
  assign out_ch.bar_time    = ent_r[0].bar.bar_time;
  assign out_ch.last        = ent_r[0].last;

endmodule
`default_nettype wire
